// File: sv/hrc_pkg.sv
// shared types and constants of the hsl to rgb converter
package hrc_pkg;

  localparam int HUE_W   = 12;
  localparam int LEVEL_W = 8;
  localparam int ANGLE_W = 9;   // reduced hue, 0..359
  localparam int TRI_W   = 6;   // triangle weight, 0..60
  localparam int CN_W    = 16;  // chroma numerator, up to 254*255
  localparam int PROD_W  = 22;  // chroma times triangle weight
  localparam int MDIFF_W = 17;  // 510*L - chroma numerator
  localparam int Q_W     = 23;  // width of the common denominator
  localparam int SUM_W   = 24;  // channel numerator before clamp
  localparam int NUM_CH  = 3;

  localparam logic [HUE_W-1:0]   TURN_X4    = 12'd1440;
  localparam logic [HUE_W-1:0]   TURN_X2    = 12'd720;
  localparam logic [HUE_W-1:0]   FULL_TURN  = 12'd360;
  localparam logic [ANGLE_W-1:0] SEXTANT    = 9'd60;
  localparam logic [LEVEL_W:0]   IN_SCALE   = 9'd255;
  localparam logic [7:0]         C_WEIGHT   = 8'd120;
  localparam logic [9:0]         L_WEIGHT   = 10'd510;
  // 2 * 60 * 255 * 255
  localparam logic [Q_W-1:0]     DENOM      = 23'd7803000;
  localparam logic [Q_W-1:0]     DENOM_HALF = 23'd3901500;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef enum logic [2:0] {
    SEXT_0 = 3'd0,
    SEXT_1 = 3'd1,
    SEXT_2 = 3'd2,
    SEXT_3 = 3'd3,
    SEXT_4 = 3'd4,
    SEXT_5 = 3'd5
  } sext_t;

endpackage

// File: sv/hrc_in_if.sv
// hsl request channel
interface hrc_in_if;
  import hrc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [HUE_W-1:0]   hue_degrees;
  logic        [LEVEL_W-1:0] saturation_level;
  logic        [LEVEL_W-1:0] lightness_level;

  modport source (
    output valid, hue_degrees, saturation_level, lightness_level,
    input  ready
  );

  modport sink (
    input  valid, hue_degrees, saturation_level, lightness_level,
    output ready
  );
endinterface

// File: sv/hrc_out_if.sv
// rgb result channel
interface hrc_out_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_level;
  logic [CHANNEL_BITS-1:0] green_level;
  logic [CHANNEL_BITS-1:0] blue_level;

  modport source (
    output valid, red_level, green_level, blue_level,
    input  ready
  );

  modport sink (
    input  valid, red_level, green_level, blue_level,
    output ready
  );
endinterface

// File: sv/hsl_to_rgb_converter.sv
// hsl to rgb converter, pipelined with a reciprocal scaling per channel
//
//   channel | dir | handshake       | payload
//   in_ch   | in  | valid / ready   | hue_degrees, saturation_level, lightness_level
//   out_ch  | out | valid / ready   | red_level, green_level, blue_level
//
// one request per cycle while the output is taken; four stages of color math, then a
// reciprocal estimate, its rounding shift, the back multiply by the denominator
// and a one-step correction of the estimate
// the whole pipeline holds while the output register is full and not taken
// reset (rst_n, synchronous) clears only the stage valid bits
module hsl_to_rgb_converter #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  hrc_in_if.sink     in_ch,
  hrc_out_if.source  out_ch
);
  import hrc_pkg::*;

  localparam int     REM_W    = Q_W + CHANNEL_BITS;
  localparam int     EST_SH   = Q_W;
  localparam int     RCP_W    = CHANNEL_BITS + 1;
  localparam int     PRD_W    = Q_W + RCP_W;
  localparam int     NUM_STG  = 8;
  localparam longint CMAX_L   = (longint'(1) << CHANNEL_BITS) - 1;
  // floor(cmax * 2^EST_SH / DENOM): the estimate is low by at most one
  localparam logic [RCP_W-1:0] RECIP    = RCP_W'((CMAX_L << EST_SH) / longint'(DENOM));
  localparam logic [PRD_W-1:0] EST_HALF = PRD_W'(longint'(1) << (EST_SH - 1));

  logic advance;

  // valid bits
  logic [NUM_STG-1:0] stg_vld_r;

  // stage 1: hue reduction and lightness span
  logic [HUE_W-1:0]   hue_mag, red0, red1, red2;
  logic [LEVEL_W:0]   two_l, l_dist;
  logic [ANGLE_W-1:0] s1_angle_r, s1_angle_nxt;
  logic [LEVEL_W-1:0] s1_span_r, s1_span_nxt;
  logic [LEVEL_W-1:0] s1_sat_r, s1_lvl_r;

  // stage 2: chroma numerator, sextant, triangle weight
  sext_t              s2_sext_r, s2_sext_nxt;
  logic [ANGLE_W-1:0] sext_base, sext_off;
  logic [TRI_W-1:0]   s2_tri_r, s2_tri_nxt;
  logic [CN_W-1:0]    s2_cn_r, s2_cn_nxt;
  logic [LEVEL_W-1:0] s2_lvl_r;

  // stage 3: products
  logic [CN_W-1:0]    s3_cn_r;
  logic [PROD_W-1:0]  s3_prod_r, s3_prod_nxt;
  logic [MDIFF_W-1:0] s3_mdiff_r, s3_mdiff_nxt;
  sext_t              s3_sext_r;

  // stage 4: channel numerators over DENOM
  logic [SUM_W-1:0]   c_num, x_num, m_num;
  logic [SUM_W-1:0]   ch_sum [NUM_CH];
  logic [Q_W-1:0]     s4_num_r [NUM_CH];
  logic [Q_W-1:0]     s4_num_nxt [NUM_CH];

  // stage 5: scaled and rounded dividend, reciprocal product
  logic [REM_W-1:0]   s5_rem_r [NUM_CH];
  logic [REM_W-1:0]   s5_rem_nxt [NUM_CH];
  logic [PRD_W-1:0]   s5_prod_r [NUM_CH];
  logic [PRD_W-1:0]   s5_prod_nxt [NUM_CH];

  // stage 6: quotient estimate
  logic [PRD_W-1:0]        est_sum [NUM_CH];
  logic [CHANNEL_BITS-1:0] s6_est_r [NUM_CH];
  logic [CHANNEL_BITS-1:0] s6_est_nxt [NUM_CH];
  logic [REM_W-1:0]        s6_rem_r [NUM_CH];

  // stage 7: estimate times denominator
  logic [CHANNEL_BITS-1:0] s7_est_r [NUM_CH];
  logic [REM_W-1:0]        s7_rem_r [NUM_CH];
  logic [REM_W-1:0]        s7_ed_r [NUM_CH];
  logic [REM_W-1:0]        s7_ed_nxt [NUM_CH];

  // stage 8: corrected level
  logic [CHANNEL_BITS-1:0] s8_lvl_r [NUM_CH];
  logic [CHANNEL_BITS-1:0] s8_lvl_nxt [NUM_CH];

  assign advance     = !stg_vld_r[NUM_STG-1] || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else if (advance) begin
      stg_vld_r <= {stg_vld_r[NUM_STG-2:0], in_ch.valid};
    end
  end

  // stage 1
  always_comb begin
    hue_mag = in_ch.hue_degrees[HUE_W-1] ? $unsigned(-in_ch.hue_degrees)
                                         : $unsigned(in_ch.hue_degrees);
    red0 = (hue_mag >= TURN_X4)  ? hue_mag - TURN_X4  : hue_mag;
    red1 = (red0 >= TURN_X2)     ? red0 - TURN_X2     : red0;
    red2 = (red1 >= FULL_TURN)   ? red1 - FULL_TURN   : red1;
    s1_angle_nxt = red2[ANGLE_W-1:0];

    two_l  = {in_ch.lightness_level, 1'b0};
    l_dist = (two_l >= IN_SCALE) ? two_l - IN_SCALE : IN_SCALE - two_l;
    s1_span_nxt = IN_SCALE[LEVEL_W-1:0] - l_dist[LEVEL_W-1:0];
  end

  // stage 2
  always_comb begin
    priority if (s1_angle_r >= 9'd300) s2_sext_nxt = SEXT_5;
    else if (s1_angle_r >= 9'd240)     s2_sext_nxt = SEXT_4;
    else if (s1_angle_r >= 9'd180)     s2_sext_nxt = SEXT_3;
    else if (s1_angle_r >= 9'd120)     s2_sext_nxt = SEXT_2;
    else if (s1_angle_r >= SEXTANT)    s2_sext_nxt = SEXT_1;
    else                               s2_sext_nxt = SEXT_0;

    unique case (s2_sext_nxt)
      SEXT_0:  sext_base = 9'd0;
      SEXT_1:  sext_base = 9'd60;
      SEXT_2:  sext_base = 9'd120;
      SEXT_3:  sext_base = 9'd180;
      SEXT_4:  sext_base = 9'd240;
      SEXT_5:  sext_base = 9'd300;
      default: sext_base = 9'd0;
    endcase
    sext_off = s1_angle_r - sext_base;

    // rising edge of the triangle in even sextants, falling in odd ones
    if (s2_sext_nxt[0]) begin
      s2_tri_nxt = TRI_W'(SEXTANT - sext_off);
    end else begin
      s2_tri_nxt = sext_off[TRI_W-1:0];
    end

    s2_cn_nxt = CN_W'(s1_span_r) * CN_W'(s1_sat_r);
  end

  // stage 3
  always_comb begin
    s3_prod_nxt  = PROD_W'(s2_cn_r) * PROD_W'(s2_tri_r);
    s3_mdiff_nxt = MDIFF_W'(L_WEIGHT) * MDIFF_W'(s2_lvl_r) - MDIFF_W'(s2_cn_r);
  end

  // stage 4
  always_comb begin
    c_num = SUM_W'(s3_cn_r) * SUM_W'(C_WEIGHT);
    x_num = {1'b0, s3_prod_r, 1'b0};
    m_num = SUM_W'(s3_mdiff_r) * SUM_W'(SEXTANT);

    unique case (s3_sext_r)
      SEXT_0: begin
        ch_sum[CH_RED] = c_num; ch_sum[CH_GREEN] = x_num; ch_sum[CH_BLUE] = '0;
      end
      SEXT_1: begin
        ch_sum[CH_RED] = x_num; ch_sum[CH_GREEN] = c_num; ch_sum[CH_BLUE] = '0;
      end
      SEXT_2: begin
        ch_sum[CH_RED] = '0; ch_sum[CH_GREEN] = c_num; ch_sum[CH_BLUE] = x_num;
      end
      SEXT_3: begin
        ch_sum[CH_RED] = '0; ch_sum[CH_GREEN] = x_num; ch_sum[CH_BLUE] = c_num;
      end
      SEXT_4: begin
        ch_sum[CH_RED] = x_num; ch_sum[CH_GREEN] = '0; ch_sum[CH_BLUE] = c_num;
      end
      default: begin
        ch_sum[CH_RED] = c_num; ch_sum[CH_GREEN] = '0; ch_sum[CH_BLUE] = x_num;
      end
    endcase

    for (int c = 0; c < NUM_CH; c++) begin
      ch_sum[c] = ch_sum[c] + m_num;
      // never above one for legal math, kept as a guard
      s4_num_nxt[c] = (ch_sum[c] > SUM_W'(DENOM)) ? DENOM : ch_sum[c][Q_W-1:0];
    end
  end

  // stage 5: num * (2^bits - 1) + denom/2, and num times the reciprocal
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s5_rem_nxt[c] = (REM_W'(s4_num_r[c]) << CHANNEL_BITS) - REM_W'(s4_num_r[c])
                    + REM_W'(DENOM_HALF);
      s5_prod_nxt[c] = PRD_W'(s4_num_r[c]) * PRD_W'(RECIP);
    end
  end

  // stage 6: rounded estimate, equal to the quotient or one below
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      est_sum[c]    = s5_prod_r[c] + EST_HALF;
      s6_est_nxt[c] = est_sum[c][EST_SH +: CHANNEL_BITS];
    end
  end

  // stage 7
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s7_ed_nxt[c] = REM_W'(s6_est_r[c]) * REM_W'(DENOM);
    end
  end

  // stage 8: bump the estimate when a whole denominator is left over
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s8_lvl_nxt[c] = (s7_rem_r[c] - s7_ed_r[c] >= REM_W'(DENOM))
                    ? s7_est_r[c] + CHANNEL_BITS'(1) : s7_est_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_angle_r <= s1_angle_nxt;
      s1_span_r  <= s1_span_nxt;
      s1_sat_r   <= in_ch.saturation_level;
      s1_lvl_r   <= in_ch.lightness_level;

      s2_sext_r  <= s2_sext_nxt;
      s2_tri_r   <= s2_tri_nxt;
      s2_cn_r    <= s2_cn_nxt;
      s2_lvl_r   <= s1_lvl_r;

      s3_cn_r    <= s2_cn_r;
      s3_prod_r  <= s3_prod_nxt;
      s3_mdiff_r <= s3_mdiff_nxt;
      s3_sext_r  <= s2_sext_r;

      for (int c = 0; c < NUM_CH; c++) begin
        s4_num_r[c]  <= s4_num_nxt[c];
        s5_rem_r[c]  <= s5_rem_nxt[c];
        s5_prod_r[c] <= s5_prod_nxt[c];
        s6_est_r[c]  <= s6_est_nxt[c];
        s6_rem_r[c]  <= s5_rem_r[c];
        s7_est_r[c]  <= s6_est_r[c];
        s7_rem_r[c]  <= s6_rem_r[c];
        s7_ed_r[c]   <= s7_ed_nxt[c];
        s8_lvl_r[c]  <= s8_lvl_nxt[c];
      end
    end
  end

  assign out_ch.valid       = stg_vld_r[NUM_STG-1];
  assign out_ch.red_level   = s8_lvl_r[CH_RED];
  assign out_ch.green_level = s8_lvl_r[CH_GREEN];
  assign out_ch.blue_level  = s8_lvl_r[CH_BLUE];

endmodule

// File: bench/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the hsl to rgb converter: bursty requests, stalling receiver
module hsl_to_rgb_converter_tb;
  import hrc_pkg::*;

  localparam int     CH_BITS     = 8;
  localparam longint LEVEL_MAX   = (longint'(1) << CH_BITS) - 1;
  // every channel is an exact fraction over 2 * 60 * 255 * 255
  localparam longint SCALE_Q     = 64'd7803000;
  localparam int     RANDOM_HSL  = 1550;
  localparam int     HOLD_CYCLES = 120;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [LEVEL_W-1:0]      sat;
    logic [LEVEL_W-1:0]      lum;
  } hsl_t;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n;

  hrc_in_if                         in_ch ();
  hrc_out_if #(.CHANNEL_BITS(CH_BITS)) out_ch ();

  hsl_to_rgb_converter #(.CHANNEL_BITS(CH_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  hsl_t hsl_todo_q[$];
  rgb_t rgb_expect_q[$];
  int   hsl_total    = 0;
  int   hsl_accepted = 0;
  int   errors       = 0;
  logic in_taken     = 1'b0;
  int   burst_left   = 0;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   hold_count   = 0;
  int   rx_cycle     = 0;
  int   stall_mode   = 0;
  logic rx_ready;

  // round half up, clamp to the channel range
  function automatic logic [CH_BITS-1:0] scale_level(longint num);
    longint lvl;
    if (num <= 0) return '0;
    if (num > SCALE_Q) num = SCALE_Q;
    lvl = (num * LEVEL_MAX + SCALE_Q / 2) / SCALE_Q;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    return lvl[CH_BITS-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb(hsl_t px);
    int     hue_abs, angle, lum_gap, chroma_n, fold, tri_w;
    longint c_n, x_n, m_n, red_n, green_n, blue_n;
    sext_t  sext;
    rgb_t   rgb;
    hue_abs = $signed(px.hue);
    if (hue_abs < 0) hue_abs = -hue_abs;
    angle = hue_abs % 360;
    lum_gap = 2 * int'(px.lum) - 255;
    if (lum_gap < 0) lum_gap = -lum_gap;
    chroma_n = (255 - lum_gap) * int'(px.sat);
    // triangle weight in sixtieths: peaks mid-sextant-pair
    fold = (angle % 120) - 60;
    if (fold < 0) fold = -fold;
    tri_w = 60 - fold;
    c_n = longint'(chroma_n) * 120;
    x_n = longint'(chroma_n) * tri_w * 2;
    m_n = (longint'(510) * int'(px.lum) - chroma_n) * 60;
    sext = sext_t'(angle / 60);
    case (sext)
      SEXT_0: begin red_n = c_n; green_n = x_n; blue_n = 0;   end
      SEXT_1: begin red_n = x_n; green_n = c_n; blue_n = 0;   end
      SEXT_2: begin red_n = 0;   green_n = c_n; blue_n = x_n; end
      SEXT_3: begin red_n = 0;   green_n = x_n; blue_n = c_n; end
      SEXT_4: begin red_n = x_n; green_n = 0;   blue_n = c_n; end
      default: begin red_n = c_n; green_n = 0;  blue_n = x_n; end
    endcase
    rgb.red   = scale_level(red_n + m_n);
    rgb.green = scale_level(green_n + m_n);
    rgb.blue  = scale_level(blue_n + m_n);
    return rgb;
  endfunction

  task automatic queue_hsl(int hue, int sat, int lum);
    hsl_t px;
    px.hue = hue[HUE_W-1:0];
    px.sat = sat[LEVEL_W-1:0];
    px.lum = lum[LEVEL_W-1:0];
    hsl_todo_q.push_back(px);
    hsl_total++;
  endtask

  task automatic check_level(string chan, logic [CH_BITS-1:0] want, logic [CH_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
    end
  endtask

  // sender: bursts with gaps, holds a request until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // request still pending
    end else if (gap_left > 0 && hold_left == 0) begin
      in_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (hsl_todo_q.size() > 0) begin
      hsl_t px;
      px = hsl_todo_q.pop_front();
      in_ch.valid            <= 1'b1;
      in_ch.hue_degrees      <= px.hue;
      in_ch.saturation_level <= px.sat;
      in_ch.lightness_level  <= px.lum;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // long receiver hold-off so the pipeline fills and backs up into the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_count < 2 && hsl_accepted >= (hold_count + 1) * 500) begin
      hold_left  <= HOLD_CYCLES;
      hold_count <= hold_count + 1;
    end
  end

  // receiver: stall pattern is redrawn at random, periodically
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rx_ready = 1'b1;
      1: rx_ready = ($urandom_range(0, 3) != 0);
      2: rx_ready = ($urandom_range(0, 3) == 0);
      default: rx_ready = rx_cycle[0];
    endcase
    out_ch.ready <= rx_ready && (hold_left == 0);
  end

  // results checked first, then the new request is predicted
  always @(posedge clk) begin
    rgb_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (rgb_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                   out_ch.red_level, out_ch.green_level, out_ch.blue_level);
        end else begin
          want = rgb_expect_q.pop_front();
          check_level("red_level", want.red, out_ch.red_level);
          check_level("green_level", want.green, out_ch.green_level);
          check_level("blue_level", want.blue, out_ch.blue_level);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        rgb_expect_q.push_back(hsl_to_rgb({in_ch.hue_degrees, in_ch.saturation_level,
                                           in_ch.lightness_level}));
        hsl_accepted++;
      end
    end
  end

  initial begin
    int hue, sat, lum;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.hue_degrees      = '0;
    in_ch.saturation_level = '0;
    in_ch.lightness_level  = '0;
    out_ch.ready           = 1'b0;

    // directed: extremes, every sextant, wraps and negative hues
    queue_hsl(0, 0, 0);
    queue_hsl(0, 0, 255);
    queue_hsl(0, 255, 128);
    queue_hsl(0, 255, 127);
    queue_hsl(60, 255, 128);
    queue_hsl(120, 255, 128);
    queue_hsl(180, 255, 128);
    queue_hsl(240, 255, 128);
    queue_hsl(300, 255, 128);
    queue_hsl(359, 255, 128);
    queue_hsl(360, 255, 128);
    queue_hsl(-1, 255, 128);
    queue_hsl(-360, 128, 64);
    queue_hsl(-2048, 255, 128);
    queue_hsl(2047, 255, 128);
    queue_hsl(2047, 255, 255);
    queue_hsl(-2048, 0, 0);
    queue_hsl(30, 255, 128);
    queue_hsl(719, 200, 100);
    queue_hsl(90, 1, 1);
    queue_hsl(210, 254, 255);
    queue_hsl(150, 255, 0);
    queue_hsl(270, 77, 200);
    queue_hsl(330, 255, 191);
    // green lands exactly on a half level and must round up
    queue_hsl(45, 255, 1);

    repeat (RANDOM_HSL) begin
      case ($urandom_range(0, 7))
        0: hue = 60 * $urandom_range(0, 34) + $urandom_range(0, 2) - 1;
        1: hue = -(60 * $urandom_range(0, 34) + $urandom_range(0, 2) - 1);
        2: hue = ($urandom_range(0, 1) == 0) ? -2048 : 2047;
        default: hue = $urandom_range(0, 4095) - 2048;
      endcase
      if (hue > 2047) hue = 2047;
      if (hue < -2048) hue = -2048;
      case ($urandom_range(0, 7))
        0: sat = 0;
        1: sat = 255;
        default: sat = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 9))
        0: lum = 0;
        1: lum = 255;
        2: lum = $urandom_range(127, 128);
        default: lum = $urandom_range(0, 255);
      endcase
      queue_hsl(hue, sat, lum);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (hsl_accepted == hsl_total);
    wait (rgb_expect_q.size() == 0);
    repeat (CH_BITS + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
sv/hrc_pkg.sv
sv/hrc_in_if.sv
sv/hrc_out_if.sv
sv/hsl_to_rgb_converter.sv
bench/hsl_to_rgb_converter_tb.sv
